// File: rtl/aks_pkg.sv
// ----------------------------------------------------------------------------
// aks_pkg: shared types, constants and functions for the AES key schedule
// Holds the S-box, the round constants, the controller state encoding and
// the command bundle that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package aks_pkg;

    localparam int WORD_W   = 32;
    localparam int NK_W     = 4;
    localparam int IDX_W    = 6;
    localparam int WIN_D    = 8;
    localparam int WIN_IW   = 3;
    localparam int RND_W    = 4;

    // Key length limits, in 32-bit words
    localparam logic [NK_W-1:0] NK_MIN   = 4'd4;
    localparam logic [NK_W-1:0] NK_MAX   = 4'd8;
    localparam logic [NK_W-1:0] NK_RESET = 4'd4;
    // Key length above which the mid-key SubWord applies
    localparam logic [NK_W-1:0] NK_SUB_MID = 4'd6;
    // Phase at which the mid-key SubWord applies
    localparam logic [WIN_IW-1:0] PH_SUB_MID = 3'd4;
    // Schedule length is 4*nk + TOTAL_OFS words
    localparam logic [IDX_W-1:0] TOTAL_OFS = 6'd28;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } aks_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              load;       // write key word into window
        logic [WIN_IW-1:0] load_idx;   // window slot for the key word
        logic              advance;    // emit head word and shift window
        logic [WIN_IW-1:0] tail_idx;   // slot of the newest word (nk-1)
        logic              sel_rot;    // RotWord + SubWord + Rcon
        logic              sel_sub;    // SubWord only
        logic [RND_W-1:0]  rnd;        // round constant index
        logic [IDX_W-1:0]  word_index; // schedule position of head word
        logic              last;       // head word ends the schedule
    } aks_cmd_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // S-box on each byte of a word
    function automatic logic [WORD_W-1:0] sub_word(input logic [WORD_W-1:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Round constant; zero past the tenth round
    function automatic logic [7:0] rcon(input logic [RND_W-1:0] r);
        logic [7:0] c;
        case (r)
            4'd1:    c = 8'h01;
            4'd2:    c = 8'h02;
            4'd3:    c = 8'h04;
            4'd4:    c = 8'h08;
            4'd5:    c = 8'h10;
            4'd6:    c = 8'h20;
            4'd7:    c = 8'h40;
            4'd8:    c = 8'h80;
            4'd9:    c = 8'h1b;
            4'd10:   c = 8'h36;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/aks_datapath.sv
// ----------------------------------------------------------------------------
// aks_datapath: key word window and round word generator
// Holds the last nk schedule words, emits the oldest one each advance and
// appends the next schedule word computed from the oldest and newest.
// ----------------------------------------------------------------------------
module aks_datapath
    import aks_pkg::*;
(
    input  logic              clk,
    input  aks_cmd_t          cmd,
    input  logic [WORD_W-1:0] key_word,
    output logic [WORD_W-1:0] round_word,
    output logic [IDX_W-1:0]  word_index,
    output logic              last_word
);

    logic [WORD_W-1:0] win_reg [WIN_D];
    logic [WORD_W-1:0] tail;
    logic [WORD_W-1:0] sub_in;
    logic [WORD_W-1:0] sub_out;
    logic [WORD_W-1:0] f_out;
    logic [WORD_W-1:0] new_word;
    logic [WORD_W-1:0] round_word_reg;
    logic [IDX_W-1:0]  word_index_reg;
    logic              last_word_reg;

    // Next schedule word: w[i-nk] ^ f(w[i-1])
    always_comb
    begin
        tail    = win_reg[cmd.tail_idx];
        sub_in  = cmd.sel_rot ? {tail[23:0], tail[31:24]} : tail;
        sub_out = sub_word(sub_in);
        if (cmd.sel_rot)
            f_out = sub_out ^ {rcon(cmd.rnd), 24'h000000};
        else if (cmd.sel_sub)
            f_out = sub_out;
        else
            f_out = tail;
        new_word = win_reg[0] ^ f_out;
    end

    // Window: key load by slot, shift toward slot 0 on advance
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            win_reg[cmd.load_idx] <= key_word;
        end
        else if (cmd.advance)
        begin
            for (int k = 0; k < WIN_D; k++)
            begin
                if (WIN_IW'(k) == cmd.tail_idx)
                    win_reg[k] <= new_word;
                else if (k < WIN_D - 1)
                    win_reg[k] <= win_reg[k + 1];
            end
        end
    end

    // Output holding register
    always_ff @(posedge clk)
    begin
        if (cmd.advance)
        begin
            round_word_reg <= win_reg[0];
            word_index_reg <= cmd.word_index;
            last_word_reg  <= cmd.last;
        end
    end

    assign round_word = round_word_reg;
    assign word_index = word_index_reg;
    assign last_word  = last_word_reg;

endmodule

// File: rtl/aks_ctrl.sv
// ----------------------------------------------------------------------------
// aks_ctrl: key schedule controller
// Counts incoming key words, then steps the datapath through the schedule
// with phase and round counters, and owns both stream handshakes.
// ----------------------------------------------------------------------------
module aks_ctrl
    import aks_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [NK_W-1:0] cfg_data,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output aks_cmd_t        cmd
);

    aks_state_t        state_reg, state_next;
    logic [NK_W-1:0]   nk_cfg_reg;
    logic [NK_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [WIN_IW-1:0] ph_reg, ph_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic              ovalid_reg, ovalid_next;

    logic [NK_W-1:0]   nk;
    logic [WIN_IW-1:0] nk_m1;
    logic [IDX_W-1:0]  last_idx;
    logic [NK_W-1:0]   cnt_inc;
    logic              accept;
    logic              advance;
    logic              at_last;

    // Effective key length, clamped to 4..8
    always_comb
    begin
        if (nk_cfg_reg < NK_MIN)
            nk = NK_MIN;
        else if (nk_cfg_reg > NK_MAX)
            nk = NK_MAX;
        else
            nk = nk_cfg_reg;
        nk_m1    = WIN_IW'(nk - 4'd1);
        last_idx = {nk, 2'b00} + TOTAL_OFS - 6'd1;
    end

    assign in_ready = (state_reg == ST_LOAD);
    assign accept   = in_ready && in_valid;
    assign cnt_inc  = cnt_reg + 4'd1;
    assign advance  = (state_reg == ST_EMIT) && (!ovalid_reg || out_ready);
    assign at_last  = (idx_reg == last_idx);

    // Next state and counters
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        ph_next     = ph_reg;
        rnd_next    = rnd_reg;
        ovalid_next = ovalid_reg;

        if (out_ready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (cnt_inc >= nk)
                    begin
                        cnt_next   = '0;
                        idx_next   = '0;
                        ph_next    = '0;
                        rnd_next   = 4'd1;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                    end
                end
            end
            ST_EMIT:
            begin
                if (advance)
                begin
                    ovalid_next = 1'b1;
                    idx_next    = idx_reg + 6'd1;
                    if (ph_reg == nk_m1)
                    begin
                        ph_next  = '0;
                        rnd_next = rnd_reg + 4'd1;
                    end
                    else
                    begin
                        ph_next = ph_reg + 3'd1;
                    end
                    if (at_last)
                        state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // Register write drops a partial key
        if (cfg_we)
            cnt_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            nk_cfg_reg <= NK_RESET;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            ph_reg     <= '0;
            rnd_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            ph_reg     <= ph_next;
            rnd_reg    <= rnd_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
                nk_cfg_reg <= cfg_data;
        end
    end

    // Datapath commands
    always_comb
    begin
        cmd.load       = accept;
        cmd.load_idx   = cnt_reg[WIN_IW-1:0];
        cmd.advance    = advance;
        cmd.tail_idx   = nk_m1;
        cmd.sel_rot    = (ph_reg == '0);
        cmd.sel_sub    = (nk > NK_SUB_MID) && (ph_reg == PH_SUB_MID);
        cmd.rnd        = rnd_reg;
        cmd.word_index = idx_reg;
        cmd.last       = at_last;
    end

    assign out_valid = ovalid_reg;

endmodule

// File: rtl/aes_key_schedule.sv
// ----------------------------------------------------------------------------
// aes_key_schedule: AES key expansion, one round-key word per beat
// Collects nk cipher key words and streams out the full 4*(nk+7) word
// schedule.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we/cfg_data set nk (4, 6 or 8; 5 and 7 also work, others clamp to
//   4..8). A write also discards any partial key. Reset sets nk to 4.
//   Slave channel: one key word per beat, first key byte in bits 31:24.
//   Key beats are taken one per cycle while the block is loading.
//   Master channel: the beat that completes the key starts the schedule;
//   the state register moves to emit and the output register then loads
//   the first round word, then one word per cycle while m_axis_tready
//   is high, 44/52/60 words for nk 4/6/8, tlast on the final word.
//   The slave side is held off (tready low) while the schedule is being
//   generated, so a new key is taken only after the generator has
//   produced the final word of the current schedule; the generator makes
//   one word per step, with a single SubWord.
//   A stall on m_axis_tready freezes generation with the pending word held
//   in the output register. After reset the block waits for the first key
//   word; no key storage is cleared.
// ----------------------------------------------------------------------------
module aes_key_schedule
    import aks_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    // Key length register
    input  logic            cfg_we,
    input  logic [NK_W-1:0] cfg_data,
    // Key words
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [31:0]     s_axis_tdata,   // [31:0] key_word
    // Round-key words
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [39:0]     m_axis_tdata,   // [31:0] round_word, [37:32] word_index
    output logic            m_axis_tlast    // last_word
);

    aks_cmd_t          cmd;
    logic [WORD_W-1:0] round_word;
    logic [IDX_W-1:0]  word_index;

    aks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    aks_datapath u_datapath (
        .clk        (clk),
        .cmd        (cmd),
        .key_word   (s_axis_tdata),
        .round_word (round_word),
        .word_index (word_index),
        .last_word  (m_axis_tlast)
    );

    // Pack output beat, zero pad to a byte boundary
    assign m_axis_tdata = {2'b00, word_index, round_word};

endmodule
